[hdl/msl_pkg.sv]
// ----------------------------------------------------------------------------
// msl_pkg
// Types and constants shared by the motor effort slew limiter modules.
// ----------------------------------------------------------------------------
package msl_pkg;

  // Field widths
  localparam int unsigned EFFORT_W  = 16;
  localparam int unsigned DUTY_W    = 15;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned RAMP_W    = 24;
  localparam int unsigned STEP_W    = 16;
  localparam int unsigned CHAN_W    = 2;
  localparam int unsigned PROD_W    = TICKS_W + RAMP_W;
  localparam int unsigned LIMIT_W   = EFFORT_W + 2;
  localparam int unsigned NUM_CMD   = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = RAMP_W;

  // Packed stream widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 40;

  // Effort and duty constants
  localparam logic signed [LIMIT_W-1:0] EFFORT_MAX = 18'sd32767;
  localparam logic signed [LIMIT_W-1:0] EFFORT_MIN = -18'sd32767;
  localparam logic [DUTY_W-1:0]         DUTY_HALF  = 15'd16384;

  // Register reset values
  localparam logic [RAMP_W-1:0] RAMP_RATE_RST  = 24'd65536;
  localparam logic [STEP_W-1:0] MAX_STEP_RST   = 16'd65535;
  localparam logic              SLOW_DECAY_RST = 1'b0;
  localparam logic [CHAN_W-1:0] RIGHT_CH_RST   = 2'd1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_RATE  = 2'd0,
    REG_MAX_STEP   = 2'd1,
    REG_SLOW_DECAY = 2'd2,
    REG_RIGHT_CH   = 2'd3
  } cfg_idx_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MULT  = 2'd1,
    ST_LIMIT = 2'd2,
    ST_CHAN  = 2'd3
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              capture;
    logic              load_prod;
    logic              load_step;
    logic              load_out;
    logic [CHAN_W-1:0] chan;
    logic              last;
  } dp_cmd_t;

endpackage

[hdl/msl_ctrl.sv]
// ----------------------------------------------------------------------------
// msl_ctrl
// Sequencer: takes one drive tick, steps the multiply, limit and per-channel
// phases, and owns the output valid flag.
// ----------------------------------------------------------------------------
module msl_ctrl #(
  parameter int unsigned NCH = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_tvalid_i,
  output logic              in_tready_o,
  input  logic              out_tready_i,
  output logic              out_tvalid_o,
  output msl_pkg::dp_cmd_t  cmd_o
);

  localparam logic [msl_pkg::CHAN_W-1:0] LAST_CH = msl_pkg::CHAN_W'(NCH - 1);

  msl_pkg::state_e state_q, state_d;
  logic [msl_pkg::CHAN_W-1:0] chan_q, chan_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free     = !out_valid_q || out_tready_i;
  assign out_tvalid_o = out_valid_q;

  // State, channel counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msl_pkg::ST_IDLE;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    chan_d       = chan_q;
    out_valid_d  = out_valid_q && !out_tready_i;
    in_tready_o  = 1'b0;
    cmd_o        = '0;
    cmd_o.chan   = chan_q;
    cmd_o.last   = (chan_q == LAST_CH);
    case (state_q)
      msl_pkg::ST_IDLE: begin
        in_tready_o = 1'b1;
        if (in_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = msl_pkg::ST_MULT;
        end
      end
      msl_pkg::ST_MULT: begin
        cmd_o.load_prod = 1'b1;
        state_d         = msl_pkg::ST_LIMIT;
      end
      msl_pkg::ST_LIMIT: begin
        cmd_o.load_step = 1'b1;
        chan_d          = '0;
        state_d         = msl_pkg::ST_CHAN;
      end
      msl_pkg::ST_CHAN: begin
        // Advance one channel whenever the output register can take it
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          if (chan_q == LAST_CH) begin
            chan_d  = '0;
            state_d = msl_pkg::ST_IDLE;
          end else begin
            chan_d = chan_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = msl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/msl_datapath.sv]
// ----------------------------------------------------------------------------
// msl_datapath
// Configuration registers, captured tick, step multiplier, per-channel
// effort limiter, previous-effort store and the output register.
// ----------------------------------------------------------------------------
module msl_datapath #(
  parameter int unsigned NCH = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [msl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [msl_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  input  logic [msl_pkg::IN_DATA_W-1:0]       in_tdata_i,
  input  msl_pkg::dp_cmd_t                    cmd_i,
  output logic [msl_pkg::OUT_DATA_W-1:0]      out_tdata_o,
  output logic                                out_tlast_o
);

  localparam int unsigned EW = msl_pkg::EFFORT_W;
  localparam int unsigned LW = msl_pkg::LIMIT_W;

  // Configuration registers
  logic [msl_pkg::RAMP_W-1:0] ramp_rate_q;
  logic [msl_pkg::STEP_W-1:0] max_step_q;
  logic                       slow_decay_q;
  logic [msl_pkg::CHAN_W-1:0] right_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_rate_q  <= msl_pkg::RAMP_RATE_RST;
      max_step_q   <= msl_pkg::MAX_STEP_RST;
      slow_decay_q <= msl_pkg::SLOW_DECAY_RST;
      right_ch_q   <= msl_pkg::RIGHT_CH_RST;
    end else if (cfg_we_i) begin
      case (msl_pkg::cfg_idx_e'(cfg_idx_i))
        msl_pkg::REG_RAMP_RATE:  ramp_rate_q  <= cfg_data_i[msl_pkg::RAMP_W-1:0];
        msl_pkg::REG_MAX_STEP:   max_step_q   <= cfg_data_i[msl_pkg::STEP_W-1:0];
        msl_pkg::REG_SLOW_DECAY: slow_decay_q <= cfg_data_i[0];
        msl_pkg::REG_RIGHT_CH:   right_ch_q   <= cfg_data_i[msl_pkg::CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Captured tick
  logic [msl_pkg::TICKS_W-1:0] ticks_q;
  logic                        oc_q;
  logic                        brq_q;
  logic [EW-1:0]               cmd_q [msl_pkg::NUM_CMD];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ticks_q <= in_tdata_i[15:0];
      oc_q    <= in_tdata_i[16];
      brq_q   <= in_tdata_i[17];
      for (int i = 0; i < msl_pkg::NUM_CMD; i++) begin
        cmd_q[i] <= in_tdata_i[18 + i*EW +: EW];
      end
    end
  end

  // Step: product, then limit to max_step
  logic [msl_pkg::PROD_W-1:0] prod_q;
  logic [msl_pkg::STEP_W-1:0] step_q;
  logic [msl_pkg::RAMP_W-1:0] prod_hi;

  assign prod_hi = prod_q[msl_pkg::PROD_W-1:16];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_prod) begin
      prod_q <= msl_pkg::PROD_W'(ticks_q) * msl_pkg::PROD_W'(ramp_rate_q);
    end
    if (cmd_i.load_step) begin
      if (prod_hi > msl_pkg::RAMP_W'(max_step_q)) begin
        step_q <= max_step_q;
      end else begin
        step_q <= prod_hi[msl_pkg::STEP_W-1:0];
      end
    end
  end

  // Select this channel's command and previous effort
  logic [EW-1:0] prev_q [NCH];
  logic [EW-1:0] prev_sel;
  logic [EW-1:0] cmd_sel;

  always_comb begin
    prev_sel = '0;
    cmd_sel  = '0;
    for (int i = 0; i < NCH; i++) begin
      if (cmd_i.chan == msl_pkg::CHAN_W'(i)) begin
        prev_sel = prev_q[i];
        cmd_sel  = cmd_q[i];
      end
    end
  end

  // Clamp to previous +/- step, then saturate; decode duty, direction and brake (all zero on overcurrent)
  logic signed [LW-1:0] last_s, step_s, lo_s, hi_s, cmd_s, lim_s;
  logic signed [EW-1:0] eff;
  logic [msl_pkg::DUTY_W-1:0] mag;
  logic [msl_pkg::DUTY_W-1:0] duty;
  logic rev, brk;

  always_comb begin
    last_s = LW'(signed'(prev_sel));
    step_s = signed'(LW'(step_q));
    cmd_s  = LW'(signed'(cmd_sel));
    lo_s   = last_s - step_s;
    hi_s   = last_s + step_s;
    lim_s  = cmd_s;
    if (lim_s < lo_s) lim_s = lo_s;
    if (lim_s > hi_s) lim_s = hi_s;
    if (lim_s > msl_pkg::EFFORT_MAX) lim_s = msl_pkg::EFFORT_MAX;
    if (lim_s < msl_pkg::EFFORT_MIN) lim_s = msl_pkg::EFFORT_MIN;
    eff = oc_q ? '0 : lim_s[EW-1:0];
    if (eff[EW-1]) begin
      mag = msl_pkg::DUTY_W'(-eff);
    end else begin
      mag = eff[msl_pkg::DUTY_W-1:0];
    end
    if (oc_q) begin
      duty = '0;
    end else if (slow_decay_q) begin
      duty = (mag >> 1) + msl_pkg::DUTY_HALF;
    end else begin
      duty = mag;
    end
    rev = !oc_q && (eff[EW-1] ^ (cmd_i.chan == right_ch_q));
    brk = !oc_q && (eff == '0) && brq_q;
  end

  // Previous effort store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCH; i++) begin
        prev_q[i] <= '0;
      end
    end else if (cmd_i.load_out) begin
      for (int i = 0; i < NCH; i++) begin
        if (cmd_i.chan == msl_pkg::CHAN_W'(i)) begin
          prev_q[i] <= eff;
        end
      end
    end
  end

  // Output register
  logic [msl_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                           out_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {3'b000, (!oc_q && slow_decay_q), oc_q, brk, rev, duty, eff,
                     cmd_i.chan};
      out_last_q <= cmd_i.last;
    end
  end

  assign out_tdata_o = out_data_q;
  assign out_tlast_o = out_last_q;

endmodule

[hdl/motor_effort_slew_limiter_top.sv]
// A tick is taken while idle, then the step product is registered, then the step is
// limited to max_step, then the channels pass one channel per cycle through the
// shared limiter while the output register can take them; a new tick is not accepted
// until the last channel of the previous tick has been loaded into the output register.
// Reset (rst_ni low, asynchronous) restores the register defaults and clears the
// previous efforts of all channels to zero.
// ----------------------------------------------------------------------------
// motor_effort_slew_limiter_top
// Slew-rate limiter for motor channel efforts, with duty and direction decode.
// ----------------------------------------------------------------------------
module motor_effort_slew_limiter_top #(
  parameter int unsigned CHANNELS = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [msl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [msl_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // elapsed_ticks[15:0], overcurrent[16], brake_request[17],
  // command_effort_0[33:18], command_effort_1[49:34], command_effort_2[65:50]
  input  logic [msl_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // Output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // channel[1:0], applied_effort[17:2], duty[32:18], reverse[33], brake[34],
  // coast[35], decay_mode[36]
  output logic [msl_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // last_of_tick
  output logic                                m_axis_tlast
);

  localparam int unsigned NCH = (CHANNELS < msl_pkg::NUM_CMD) ? CHANNELS
                                                               : msl_pkg::NUM_CMD;

  msl_pkg::dp_cmd_t cmd;

  msl_ctrl #(
    .NCH (NCH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tvalid_i  (s_axis_tvalid),
    .in_tready_o  (s_axis_tready),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .cmd_o        (cmd)
  );

  msl_datapath #(
    .NCH (NCH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_tdata_i  (s_axis_tdata),
    .cmd_i       (cmd),
    .out_tdata_o (m_axis_tdata),
    .out_tlast_o (m_axis_tlast)
  );

endmodule
